/* design/dble_pkg.sv */
// ----------------------------------------------------------------------------
// Diagnostic block link engine package
// Shared types, codes and sizes for the block link engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dble_pkg;

  // Receive buffer size in bytes; overflow is flagged when the count reaches it.
  localparam int RX_BUFFER_BYTES = 64;
  localparam logic [8:0] RX_FULL_COUNT = 9'(RX_BUFFER_BYTES);

  localparam logic [7:0] END_MARK = 8'h03;
  localparam logic [7:0] MIN_LENGTH = 8'h03;
  localparam logic [7:0] ALL_ONES = 8'hFF;

  // Result queue.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    FUNC_RX_START  = 3'd0,
    FUNC_HOST_BYTE = 3'd1,
    FUNC_LINE_BYTE = 3'd2,
    FUNC_TIMEOUT   = 3'd3,
    FUNC_NEW_CONN  = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ACT_DRIVE    = 2'd0,
    ACT_RX_BYTE  = 2'd1,
    ACT_TX_BYTE  = 2'd2,
    ACT_FINISHED = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TIMEOUT    = 3'd1,
    ST_BAD_ECHO   = 3'd2,
    ST_BAD_COMPL  = 3'd3,
    ST_BAD_LENGTH = 3'd4,
    ST_BAD_END    = 3'd5,
    ST_OVERFLOW   = 3'd6
  } status_t;

  typedef enum logic [5:0] {
    MODE_IDLE     = 6'b000001,
    MODE_RX_BYTE  = 6'b000010,
    MODE_RX_ECHO  = 6'b000100,
    MODE_TX_READY = 6'b001000,
    MODE_TX_ECHO  = 6'b010000,
    MODE_TX_COMPL = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] line_byte;
    logic [7:0] byte_index;
    logic [2:0] status;
    logic       last;
  } result_t;

  function automatic result_t make_result(action_t act, logic [7:0] lb,
                                          logic [7:0] idx, status_t st,
                                          logic lst);
    result_t r;
    r.action     = act;
    r.line_byte  = lb;
    r.byte_index = idx;
    r.status     = st;
    r.last       = lst;
    return r;
  endfunction

  // A finish beat carries zero byte and index and always closes the item.
  function automatic result_t finish_result(status_t st);
    return make_result(ACT_FINISHED, 8'h00, 8'h00, st, 1'b1);
  endfunction

endpackage

`default_nettype wire

/* design/diag_block_link_engine.sv */
// ----------------------------------------------------------------------------
// Diagnostic block link engine
// Block layer of a single-wire diagnostic link with per-byte complement
// handshake, receive and send directions.
// ----------------------------------------------------------------------------
// The engine takes one event beat per clock cycle (start receive, host byte,
// line byte, timeout, new connection) and updates its link state in that same
// cycle; the result beats an event causes (none, one or two) are written into
// a four-entry result queue that feeds the output channel, one beat per cycle while out_stall is low.
// in_stall rises while three or more results are still queued, so the input
// runs at one event per cycle as long as the output drains at the same rate;
// an event that yields two results (a finish after a byte) needs two output
// beats, and the queue depth sets how much of that the input can run ahead.
// Every beat except an ignored or silent one ends with a result whose last
// bit is set. There is no configuration port and no start-up sweep.
`timescale 1ns / 1ps
`default_nettype none

module diag_block_link_engine
  import dble_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  // event channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] func,
  input  wire logic [7:0] data,
  // result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      action,
  output logic [7:0]      line_byte,
  output logic [7:0]      byte_index,
  output logic [2:0]      status,
  output logic            last
);

  // Link state.
  mode_t      link_mode, link_mode_next;
  logic [7:0] rx_count, rx_count_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] block_counter, block_counter_next;
  logic       first_block, first_block_next;
  logic [7:0] pending_byte, pending_byte_next;
  logic [7:0] tx_length, tx_length_next;
  logic [7:0] tx_position, tx_position_next;

  // Results of the current event.
  result_t    res0, res1;
  logic [1:0] res_count;

  // Working values of the event logic.
  logic       in_fire;
  logic       do_take;
  logic [7:0] take_byte;
  logic [8:0] take_count;
  logic [7:0] take_left;
  logic [7:0] tx_len_sel, tx_pos_sel, tx_cnt_sel, tx_byte;
  logic [7:0] data_inv, pending_inv;

  assign in_fire     = in_valid && !in_stall;
  assign data_inv    = data ^ ALL_ONES;
  assign pending_inv = pending_byte ^ ALL_ONES;

  always_comb begin
    link_mode_next     = link_mode;
    rx_count_next      = rx_count;
    bytes_left_next    = bytes_left;
    block_counter_next = block_counter;
    first_block_next   = first_block;
    pending_byte_next  = pending_byte;
    tx_length_next     = tx_length;
    tx_position_next   = tx_position;
    res0               = '0;
    res1               = '0;
    res_count          = 2'd0;
    do_take            = 1'b0;
    take_byte          = data;
    take_count         = {1'b0, rx_count} + 9'd1;
    take_left          = bytes_left;

    // A send block starts from idle with its length byte; later bytes come
    // while the engine waits for the host.
    tx_len_sel = (link_mode == MODE_IDLE) ? data : tx_length;
    tx_pos_sel = (link_mode == MODE_IDLE) ? 8'h00 : tx_position;
    tx_cnt_sel = (link_mode == MODE_IDLE) ? block_counter + 8'd1 : block_counter;
    if (tx_pos_sel == tx_len_sel) begin
      tx_byte = END_MARK;
    end else if (tx_pos_sel == 8'd1) begin
      tx_byte = tx_cnt_sel;
    end else begin
      tx_byte = data;
    end

    case (func)
      FUNC_RX_START: begin
        rx_count_next   = 8'h00;
        bytes_left_next = 8'h01;
        link_mode_next  = MODE_RX_BYTE;
      end
      FUNC_HOST_BYTE: begin
        if (link_mode inside {MODE_IDLE, MODE_TX_READY}) begin
          tx_length_next     = tx_len_sel;
          tx_position_next   = tx_pos_sel;
          block_counter_next = tx_cnt_sel;
          pending_byte_next  = tx_byte;
          link_mode_next     = MODE_TX_ECHO;
          res0      = make_result(ACT_DRIVE, tx_byte, tx_pos_sel, ST_OK, 1'b1);
          res_count = 2'd1;
        end
      end
      FUNC_LINE_BYTE: begin
        case (link_mode)
          MODE_RX_BYTE: begin
            if (rx_count == 8'h00 || bytes_left > 8'h01) begin
              // Answer with the complement and wait for its echo.
              pending_byte_next = data_inv;
              link_mode_next    = MODE_RX_ECHO;
              res0      = make_result(ACT_DRIVE, data_inv, rx_count, ST_OK, 1'b1);
              res_count = 2'd1;
            end else if (data != END_MARK) begin
              res0           = finish_result(ST_BAD_END);
              res_count      = 2'd1;
              link_mode_next = MODE_IDLE;
            end else begin
              do_take   = 1'b1;
              take_byte = data;
            end
          end
          MODE_RX_ECHO: begin
            if (data != pending_byte) begin
              res0           = finish_result(ST_BAD_ECHO);
              res_count      = 2'd1;
              link_mode_next = MODE_IDLE;
            end else begin
              do_take   = 1'b1;
              take_byte = pending_inv;
            end
          end
          MODE_TX_ECHO: begin
            if (data != pending_byte) begin
              res0           = finish_result(ST_BAD_ECHO);
              res_count      = 2'd1;
              link_mode_next = MODE_IDLE;
            end else if (tx_position == tx_length) begin
              // The end marker gets no complement: the block is done.
              res0 = make_result(ACT_TX_BYTE, pending_byte, tx_position, ST_OK, 1'b0);
              res1           = finish_result(ST_OK);
              res_count      = 2'd2;
              link_mode_next = MODE_IDLE;
            end else begin
              link_mode_next = MODE_TX_COMPL;
            end
          end
          MODE_TX_COMPL: begin
            if (data != pending_inv) begin
              res0           = finish_result(ST_BAD_COMPL);
              res_count      = 2'd1;
              link_mode_next = MODE_IDLE;
            end else begin
              res0 = make_result(ACT_TX_BYTE, pending_byte, tx_position, ST_OK, 1'b1);
              res_count        = 2'd1;
              tx_position_next = tx_position + 8'd1;
              link_mode_next   = MODE_TX_READY;
            end
          end
          default: begin
          end
        endcase
      end
      FUNC_TIMEOUT: begin
        if (link_mode != MODE_IDLE) begin
          res0           = finish_result(ST_TIMEOUT);
          res_count      = 2'd1;
          link_mode_next = MODE_IDLE;
        end
      end
      FUNC_NEW_CONN: begin
        first_block_next = 1'b1;
        link_mode_next   = MODE_IDLE;
      end
      default: begin
      end
    endcase

    // A received byte that has passed its handshake is stored, reported and
    // checked against length, buffer size and the end of the block.
    if (do_take) begin
      rx_count_next = take_count[7:0];
      res0 = make_result(ACT_RX_BYTE, take_byte, rx_count, ST_OK, 1'b0);
      if (take_count >= RX_FULL_COUNT) begin
        res1           = finish_result(ST_OVERFLOW);
        res_count      = 2'd2;
        link_mode_next = MODE_IDLE;
      end else if (take_count == 9'd1 && take_byte < MIN_LENGTH) begin
        res1           = finish_result(ST_BAD_LENGTH);
        res_count      = 2'd2;
        link_mode_next = MODE_IDLE;
      end else begin
        if (take_count == 9'd1) begin
          take_left = take_byte;
        end else begin
          if (take_count == 9'd2) begin
            if (first_block) begin
              block_counter_next = take_byte;
              first_block_next   = 1'b0;
            end else begin
              block_counter_next = block_counter + 8'd1;
            end
          end
          take_left = bytes_left - 8'd1;
        end
        bytes_left_next = take_left;
        if (take_left == 8'h00) begin
          res1           = finish_result(ST_OK);
          res_count      = 2'd2;
          link_mode_next = MODE_IDLE;
        end else begin
          res0.last      = 1'b1;
          res_count      = 2'd1;
          link_mode_next = MODE_RX_BYTE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_mode     <= MODE_IDLE;
      rx_count      <= 8'h00;
      bytes_left    <= 8'h01;
      block_counter <= 8'h00;
      first_block   <= 1'b1;
      pending_byte  <= 8'h00;
      tx_length     <= 8'h00;
      tx_position   <= 8'h00;
    end else if (in_fire) begin
      link_mode     <= link_mode_next;
      rx_count      <= rx_count_next;
      bytes_left    <= bytes_left_next;
      block_counter <= block_counter_next;
      first_block   <= first_block_next;
      pending_byte  <= pending_byte_next;
      tx_length     <= tx_length_next;
      tx_position   <= tx_position_next;
    end
  end

  // Result queue: up to two beats are written per event, one is read per cycle unless out_stall holds it.
  result_t           queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] q_count;
  logic [1:0]        push_count;
  logic              pop;

  assign push_count = in_fire ? res_count : 2'd0;
  assign out_valid  = (q_count != '0);
  assign pop        = out_valid && !out_stall;
  // Room for two results must be left before an event is taken.
  assign in_stall   = (q_count > QCNT_W'(QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      wr_ptr  <= wr_ptr + QPTR_W'(push_count);
      rd_ptr  <= rd_ptr + QPTR_W'(pop);
      q_count <= q_count + QCNT_W'(push_count) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (push_count == 2'd2) begin
      queue[wr_ptr + QPTR_W'(1)] <= res1;
    end
  end

  assign action     = queue[rd_ptr].action;
  assign line_byte  = queue[rd_ptr].line_byte;
  assign byte_index = queue[rd_ptr].byte_index;
  assign status     = queue[rd_ptr].status;
  assign last       = queue[rd_ptr].last;

  // The result queue never holds more than its depth.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCNT_W'(QUEUE_DEPTH))
    else $error("result queue count beyond depth");

  // A timeout taken while busy always returns the link to idle.
  a_timeout_idle: assert property (@(posedge clk) disable iff (rst)
    (in_fire && func == FUNC_TIMEOUT && link_mode != MODE_IDLE)
      |=> link_mode == MODE_IDLE)
    else $error("timeout did not end the operation");

  // Once a receive is under way, more bytes are always expected.
  a_rx_left: assert property (@(posedge clk) disable iff (rst)
    (link_mode == MODE_RX_BYTE && rx_count != 8'h00) |-> bytes_left != 8'h00)
    else $error("receive waiting with no bytes left");

  // A send never runs past its length byte.
  a_tx_bound: assert property (@(posedge clk) disable iff (rst)
    (link_mode == MODE_TX_READY || link_mode == MODE_TX_ECHO ||
     link_mode == MODE_TX_COMPL) |-> tx_position <= tx_length)
    else $error("send position past block length");

endmodule

`default_nettype wire

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// Block link engine testbench
// Drives event beats into the diagnostic block link engine and checks every
// result beat against a cycle-free model of the link layer kept in this file.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import dble_pkg::*;

  // Event codes the engine does not define; it must ignore them.
  localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

  // Hard ceiling on the run length, far above any correct run.
  localparam int CYCLE_LIMIT = 2000000;
  // Number of event beats that actually move the engine in the random part.
  localparam int RANDOM_EVENTS = 1000;
  // Drain time after the last expected result has arrived.
  localparam int DRAIN_CYCLES = 20;

  localparam result_t NO_BEAT = '0;

  // One stimulus row. When fixed_exp is set, the expected results are the
  // ones typed into the row rather than the ones the link model derives.
  typedef struct packed {
    logic [2:0] fn;
    logic [7:0] val;
    logic       fixed_exp;
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } vector_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] func = '0;
  logic [7:0] data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] action;
  logic [7:0] line_byte;
  logic [7:0] byte_index;
  logic [2:0] status;
  logic       last;

  diag_block_link_engine DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .data       (data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .action     (action),
    .line_byte  (line_byte),
    .byte_index (byte_index),
    .status     (status),
    .last       (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Link model state. It mirrors the engine's registers and is advanced once
  // for every event beat the engine accepts.
  // --------------------------------------------------------------------------
  mode_t      lnk_mode  = MODE_IDLE;
  logic [7:0] rx_cnt    = 8'h00;
  logic [7:0] remaining = 8'h01;
  logic [7:0] blk_ctr   = 8'h00;
  logic       first_blk = 1'b1;
  logic [7:0] held_byte = 8'h00;
  logic [7:0] tx_len    = 8'h00;
  logic [7:0] tx_pos    = 8'h00;

  // Result beats still owed by the engine, oldest first.
  result_t    pending_results[$];

  int         mismatches = 0;
  int         moved_events = 0;
  // While quiet is set neither side inserts gaps.
  bit         quiet = 1'b0;

  task automatic push_beat(action_t act, logic [7:0] lb, logic [7:0] idx,
                           status_t st, logic lst);
    result_t r;
    r.action     = act;
    r.line_byte  = lb;
    r.byte_index = idx;
    r.status     = st;
    r.last       = lst;
    pending_results.push_back(r);
  endtask

  // A finish beat always closes the operation and drops the link to idle.
  task automatic push_finish(status_t st);
    push_beat(ACT_FINISHED, 8'h00, 8'h00, st, 1'b1);
    lnk_mode = MODE_IDLE;
  endtask

  // A received byte has passed its handshake: count it, report it and check
  // the length, block counter and buffer limits.
  task automatic store_rx_byte(logic [7:0] c);
    logic [7:0] idx;
    logic [8:0] cnt;
    idx = rx_cnt;
    cnt = {1'b0, rx_cnt} + 9'd1;
    rx_cnt = cnt[7:0];
    // The byte that fills the buffer is still reported before the overflow.
    if (cnt >= 9'(RX_BUFFER_BYTES)) begin
      push_beat(ACT_RX_BYTE, c, idx, ST_OK, 1'b0);
      push_finish(ST_OVERFLOW);
      return;
    end
    if (cnt == 9'd1) begin
      if (c < MIN_LENGTH) begin
        push_beat(ACT_RX_BYTE, c, idx, ST_OK, 1'b0);
        push_finish(ST_BAD_LENGTH);
        return;
      end
      remaining = c;
    end else begin
      // The counter is learned from the first block after a new connection
      // and simply advanced on every later one.
      if (cnt == 9'd2) begin
        if (first_blk) begin
          blk_ctr = c;
          first_blk = 1'b0;
        end else begin
          blk_ctr = blk_ctr + 8'd1;
        end
      end
      remaining = remaining - 8'd1;
    end
    if (remaining == 8'd0) begin
      push_beat(ACT_RX_BYTE, c, idx, ST_OK, 1'b0);
      push_finish(ST_OK);
    end else begin
      push_beat(ACT_RX_BYTE, c, idx, ST_OK, 1'b1);
      lnk_mode = MODE_RX_BYTE;
    end
  endtask

  task automatic predict_event(logic [2:0] fn, logic [7:0] val);
    logic [7:0] b;
    case (fn)
      FUNC_RX_START: begin
        // Any running operation is dropped without a result.
        rx_cnt = 8'h00;
        remaining = 8'h01;
        lnk_mode = MODE_RX_BYTE;
      end
      FUNC_HOST_BYTE: begin
        // The first host beat in idle carries the length and opens a send.
        if (lnk_mode == MODE_IDLE) begin
          tx_len = val;
          tx_pos = 8'h00;
          blk_ctr = blk_ctr + 8'd1;
        end
        if (lnk_mode == MODE_IDLE || lnk_mode == MODE_TX_READY) begin
          // The end marker wins over the counter slot for a length of one.
          if (tx_pos == tx_len) b = END_MARK;
          else if (tx_pos == 8'd1) b = blk_ctr;
          else b = val;
          held_byte = b;
          lnk_mode = MODE_TX_ECHO;
          push_beat(ACT_DRIVE, b, tx_pos, ST_OK, 1'b1);
        end
      end
      FUNC_LINE_BYTE: begin
        case (lnk_mode)
          MODE_RX_BYTE: begin
            if (rx_cnt == 8'h00 || remaining > 8'd1) begin
              held_byte = val ^ ALL_ONES;
              lnk_mode = MODE_RX_ECHO;
              push_beat(ACT_DRIVE, held_byte, rx_cnt, ST_OK, 1'b1);
            end else if (val != END_MARK) begin
              push_finish(ST_BAD_END);
            end else begin
              // The end marker is taken without a complement.
              store_rx_byte(val);
            end
          end
          MODE_RX_ECHO: begin
            if (val != held_byte) push_finish(ST_BAD_ECHO);
            else store_rx_byte(held_byte ^ ALL_ONES);
          end
          MODE_TX_ECHO: begin
            if (val != held_byte) begin
              push_finish(ST_BAD_ECHO);
            end else if (tx_pos == tx_len) begin
              push_beat(ACT_TX_BYTE, held_byte, tx_pos, ST_OK, 1'b0);
              push_finish(ST_OK);
            end else begin
              lnk_mode = MODE_TX_COMPL;
            end
          end
          MODE_TX_COMPL: begin
            if (val != (held_byte ^ ALL_ONES)) begin
              push_finish(ST_BAD_COMPL);
            end else begin
              push_beat(ACT_TX_BYTE, held_byte, tx_pos, ST_OK, 1'b1);
              tx_pos = tx_pos + 8'd1;
              lnk_mode = MODE_TX_READY;
            end
          end
          default: ;
        endcase
      end
      FUNC_TIMEOUT: begin
        if (lnk_mode != MODE_IDLE) push_finish(ST_TIMEOUT);
      end
      FUNC_NEW_CONN: begin
        // The block counter survives; only its source is re-armed.
        first_blk = 1'b1;
        lnk_mode = MODE_IDLE;
      end
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Gap lengths shared by both sides: mostly none, often short, rarely long.
  // --------------------------------------------------------------------------
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet) return 0;
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic vector_t plain(logic [2:0] fn, logic [7:0] val);
    vector_t v;
    v = '0;
    v.fn = fn;
    v.val = val;
    return v;
  endfunction

  function automatic vector_t typed_row(logic [2:0] fn, logic [7:0] val,
                                        logic [1:0] n, result_t r0, result_t r1);
    vector_t v;
    v.fn = fn;
    v.val = val;
    v.fixed_exp = 1'b1;
    v.n = n;
    v.r0 = r0;
    v.r1 = r1;
    return v;
  endfunction

  // Present one event beat, hold it until the engine takes it, then advance
  // the link model. Valid is only lowered when a gap follows, so back to back
  // beats never see valid dropped and raised in the same step.
  task automatic issue(vector_t v);
    int    gap;
    int    depth;
    mode_t prior_mode;
    in_valid <= 1'b1;
    func <= v.fn;
    data <= v.val;
    do @(posedge clk); while (in_stall);
    depth = pending_results.size();
    prior_mode = lnk_mode;
    predict_event(v.fn, v.val);
    if (pending_results.size() > depth || lnk_mode != prior_mode ||
        v.fn == FUNC_RX_START)
      moved_events++;
    if (v.fixed_exp) begin
      while (pending_results.size() > depth) void'(pending_results.pop_back());
      if (v.n > 0) pending_results.push_back(v.r0);
      if (v.n > 1) pending_results.push_back(v.r1);
    end
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // A single stray or control beat, dropped into the middle of sequences.
  task automatic disturb();
    int pick;
    pick = $urandom_range(0, 5);
    case (pick)
      0: issue(plain(FUNC_TIMEOUT, 8'($urandom)));
      1: issue(plain(FUNC_NEW_CONN, 8'($urandom)));
      2: issue(plain(FUNC_HOST_BYTE, 8'($urandom)));
      3: issue(plain(FUNC_LINE_BYTE, 8'($urandom)));
      4: issue(plain(FUNC_RX_START, 8'($urandom)));
      default: issue(plain(3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI)),
                           8'($urandom)));
    endcase
  endtask

  // One received block as the far end would send it: each byte followed by
  // the echo of the complement the engine drives, then the end marker. Now
  // and then an echo is damaged or a stray beat slips in.
  task automatic random_receive();
    int         r;
    int         len;
    int         nbytes;
    logic [7:0] b;
    logic [7:0] echo;
    issue(plain(FUNC_RX_START, 8'($urandom)));
    r = $urandom_range(0, 99);
    if (r < 6) len = $urandom_range(0, 2);
    else if (r < 12) len = $urandom_range(40, 255);
    else len = $urandom_range(3, 16);
    // Blocks at or past the buffer size stop at the overflow.
    nbytes = (len < 3) ? 1 : ((len < RX_BUFFER_BYTES) ? len : RX_BUFFER_BYTES);
    for (int k = 0; k < nbytes; k++) begin
      if ($urandom_range(0, 199) == 0) disturb();
      b = (k == 0) ? 8'(len) : 8'($urandom);
      issue(plain(FUNC_LINE_BYTE, b));
      if (lnk_mode != MODE_RX_ECHO) return;
      echo = b ^ ALL_ONES;
      if ($urandom_range(0, 99) == 0) echo = echo ^ (8'h01 << $urandom_range(0, 7));
      issue(plain(FUNC_LINE_BYTE, echo));
      if (lnk_mode == MODE_IDLE) return;
    end
    b = END_MARK;
    if ($urandom_range(0, 49) == 0) b = 8'($urandom);
    issue(plain(FUNC_LINE_BYTE, b));
  endtask

  // One sent block: the host hands over every position, the line returns the
  // echo of what the engine drove and then its complement.
  task automatic random_send(int len);
    logic [7:0] echo;
    for (int pos = 0; pos <= len; pos++) begin
      if ($urandom_range(0, 149) == 0) disturb();
      issue(plain(FUNC_HOST_BYTE, (pos == 0) ? 8'(len) : 8'($urandom)));
      if (lnk_mode != MODE_TX_ECHO) return;
      echo = held_byte;
      if ($urandom_range(0, 99) == 0) echo = echo ^ (8'h01 << $urandom_range(0, 7));
      issue(plain(FUNC_LINE_BYTE, echo));
      if (lnk_mode != MODE_TX_COMPL) return;
      echo = held_byte ^ ALL_ONES;
      if ($urandom_range(0, 99) == 0) echo = echo ^ (8'h01 << $urandom_range(0, 7));
      issue(plain(FUNC_LINE_BYTE, echo));
      if (lnk_mode != MODE_TX_READY) return;
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall runs, and a check of every accepted beat.
  // --------------------------------------------------------------------------
  initial begin
    int hold;
    forever begin
      hold = gap_len();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch_results
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %0h %0h %0h %0h %0h",
                 $time, action, line_byte, byte_index, status, last);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("action", 8'(want.action), 8'(action));
        check_field("line_byte", want.line_byte, line_byte);
        check_field("byte_index", want.byte_index, byte_index);
        check_field("status", 8'(want.status), 8'(status));
        check_field("last", 8'(want.last), 8'(last));
      end
    end
  end

  // Watchdog: a stuck handshake ends the run here.
  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus: a directed table first, then random link traffic.
  // --------------------------------------------------------------------------
  initial begin
    vector_t rows[$];
    int      r;
    bit      long_send_done;
    long_send_done = 1'b0;

    // Stray events after reset give nothing.
    rows.push_back(typed_row(FUNC_TIMEOUT, 8'h00, 2'd0, NO_BEAT, NO_BEAT));
    rows.push_back(typed_row(FUNC_LINE_BYTE, 8'h00, 2'd0, NO_BEAT, NO_BEAT));
    rows.push_back(typed_row(FUNC_SPARE_HI, 8'hFF, 2'd0, NO_BEAT, NO_BEAT));
    // A send of length zero is a lone end marker.
    rows.push_back(typed_row(FUNC_HOST_BYTE, 8'h00, 2'd1,
                             result_t'{ACT_DRIVE, END_MARK, 8'h00, ST_OK, 1'b1}, NO_BEAT));
    rows.push_back(typed_row(FUNC_LINE_BYTE, END_MARK, 2'd2,
                             result_t'{ACT_TX_BYTE, END_MARK, 8'h00, ST_OK, 1'b0},
                             result_t'{ACT_FINISHED, 8'h00, 8'h00, ST_OK, 1'b1}));
    // Length one: the end marker takes the counter slot; then a bad echo.
    rows.push_back(plain(FUNC_HOST_BYTE, 8'h01));
    rows.push_back(plain(FUNC_LINE_BYTE, 8'h01));
    rows.push_back(plain(FUNC_LINE_BYTE, 8'hFE));
    rows.push_back(plain(FUNC_HOST_BYTE, 8'hAB));
    rows.push_back(typed_row(FUNC_LINE_BYTE, 8'h00, 2'd1,
                             result_t'{ACT_FINISHED, 8'h00, 8'h00, ST_BAD_ECHO, 1'b1},
                             NO_BEAT));
    // A good echo followed by a wrong complement.
    rows.push_back(plain(FUNC_HOST_BYTE, 8'h05));
    rows.push_back(plain(FUNC_LINE_BYTE, 8'h05));
    rows.push_back(typed_row(FUNC_LINE_BYTE, 8'h00, 2'd1,
                             result_t'{ACT_FINISHED, 8'h00, 8'h00, ST_BAD_COMPL, 1'b1},
                             NO_BEAT));
    // The counter is inserted at position one, then a timeout ends the send.
    rows.push_back(plain(FUNC_HOST_BYTE, 8'h02));
    rows.push_back(plain(FUNC_LINE_BYTE, 8'h02));
    rows.push_back(plain(FUNC_LINE_BYTE, 8'hFD));
    rows.push_back(plain(FUNC_HOST_BYTE, 8'h5A));
    rows.push_back(typed_row(FUNC_TIMEOUT, 8'h00, 2'd1,
                             result_t'{ACT_FINISHED, 8'h00, 8'h00, ST_TIMEOUT, 1'b1},
                             NO_BEAT));
    // Receive with a zero length byte; a host beat in between is ignored.
    rows.push_back(plain(FUNC_RX_START, 8'h00));
    rows.push_back(plain(FUNC_LINE_BYTE, 8'h00));
    rows.push_back(typed_row(FUNC_HOST_BYTE, 8'h11, 2'd0, NO_BEAT, NO_BEAT));
    rows.push_back(typed_row(FUNC_LINE_BYTE, 8'hFF, 2'd2,
                             result_t'{ACT_RX_BYTE, 8'h00, 8'h00, ST_OK, 1'b0},
                             result_t'{ACT_FINISHED, 8'h00, 8'h00, ST_BAD_LENGTH, 1'b1}));
    // New connection, then a three byte block that ends without its marker.
    rows.push_back(typed_row(FUNC_NEW_CONN, 8'h00, 2'd0, NO_BEAT, NO_BEAT));
    rows.push_back(plain(FUNC_RX_START, 8'h00));
    rows.push_back(plain(FUNC_LINE_BYTE, 8'h03));
    rows.push_back(plain(FUNC_LINE_BYTE, 8'hFC));
    rows.push_back(plain(FUNC_LINE_BYTE, 8'h80));
    rows.push_back(plain(FUNC_LINE_BYTE, 8'h7F));
    rows.push_back(plain(FUNC_LINE_BYTE, 8'h01));
    rows.push_back(plain(FUNC_LINE_BYTE, 8'hFE));
    rows.push_back(typed_row(FUNC_LINE_BYTE, 8'h04, 2'd1,
                             result_t'{ACT_FINISHED, 8'h00, 8'h00, ST_BAD_END, 1'b1},
                             NO_BEAT));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) issue(rows[i]);

    // Random traffic: mostly well-formed blocks in both directions with a
    // share of noise. The first send covers the longest possible block.
    moved_events = 0;
    while (moved_events < RANDOM_EVENTS) begin
      if ($urandom_range(0, 11) == 0) quiet = ~quiet;
      r = $urandom_range(0, 99);
      if (r < 45) begin
        random_receive();
      end else if (r < 80) begin
        if (!long_send_done) begin
          long_send_done = 1'b1;
          random_send(255);
        end else begin
          r = $urandom_range(0, 99);
          if (r < 70) random_send($urandom_range(0, 8));
          else if (r < 95) random_send($urandom_range(9, 40));
          else random_send($urandom_range(41, 254));
        end
      end else if (r < 90) begin
        repeat ($urandom_range(1, 3)) disturb();
      end else begin
        issue(plain(($urandom_range(0, 1) == 0) ? FUNC_TIMEOUT : FUNC_NEW_CONN,
                    8'($urandom)));
      end
    end

    quiet = 1'b0;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
